FILE: src/rational_fraction_alu_core_macros.svh
// Assertion macros shared by the rational fraction ALU RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef RATIONAL_FRACTION_ALU_CORE_MACROS_SVH
`define RATIONAL_FRACTION_ALU_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define RFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rfa assertion failed");

// Next-cycle implication, disabled during reset.
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rfa assertion failed");

`else

`define RFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/rfa_pkg.sv
// Types, constants and the microcode program of the rational fraction ALU.
// Depends on nothing; used by rfa_div and rational_fraction_alu_core.
package rfa_pkg;

	// Output field widths.
	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 32;

	// Operation codes of the request.
	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	// Datapath operations selected by a control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_A,
		OP_LD_NUM,
		OP_MUL_B,
		OP_ADD_NUM,
		OP_MUL_D,
		OP_LD_DEN,
		OP_GCD_INIT,
		OP_GCD_STEP,
		OP_GCD_FIN,
		OP_DIV_LOAD,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_EMIT
	} op_t;

	// Jump conditions of a control word.
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_REQ,
		C_MULDIV,
		C_GCD_BUSY,
		C_G_ZERO,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	// Step addresses of the program.
	localparam pc_t STEP_IDLE     = 4'd0;
	localparam pc_t STEP_MUL_A    = 4'd1;
	localparam pc_t STEP_LD_NUM   = 4'd2;
	localparam pc_t STEP_MUL_B    = 4'd3;
	localparam pc_t STEP_ADD_NUM  = 4'd4;
	localparam pc_t STEP_MUL_D    = 4'd5;
	localparam pc_t STEP_LD_DEN   = 4'd6;
	localparam pc_t STEP_GCD_INIT = 4'd7;
	localparam pc_t STEP_GCD_STEP = 4'd8;
	localparam pc_t STEP_GCD_FIN  = 4'd9;
	localparam pc_t STEP_DIV_LOAD = 4'd10;
	localparam pc_t STEP_DIV_STEP = 4'd11;
	localparam pc_t STEP_DIV_END  = 4'd12;
	localparam pc_t STEP_EMIT     = 4'd13;
	localparam pc_t STEP_LAST     = STEP_EMIT;

	// One control word: operation, jump condition and jump target.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	// Control of one divider lane.
	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	// The microcode read-only table.
	function automatic uword_t ucode_rom(input pc_t pc);
		uword_t w;
		unique case (pc)
			STEP_IDLE:     w = '{OP_LOAD,     C_NO_REQ,   STEP_IDLE};
			STEP_MUL_A:    w = '{OP_MUL_A,    C_NEXT,     STEP_IDLE};
			STEP_LD_NUM:   w = '{OP_LD_NUM,   C_MULDIV,   STEP_MUL_D};
			STEP_MUL_B:    w = '{OP_MUL_B,    C_NEXT,     STEP_IDLE};
			STEP_ADD_NUM:  w = '{OP_ADD_NUM,  C_NEXT,     STEP_IDLE};
			STEP_MUL_D:    w = '{OP_MUL_D,    C_NEXT,     STEP_IDLE};
			STEP_LD_DEN:   w = '{OP_LD_DEN,   C_NEXT,     STEP_IDLE};
			STEP_GCD_INIT: w = '{OP_GCD_INIT, C_NEXT,     STEP_IDLE};
			STEP_GCD_STEP: w = '{OP_GCD_STEP, C_GCD_BUSY, STEP_GCD_STEP};
			STEP_GCD_FIN:  w = '{OP_GCD_FIN,  C_NEXT,     STEP_IDLE};
			STEP_DIV_LOAD: w = '{OP_DIV_LOAD, C_G_ZERO,   STEP_EMIT};
			STEP_DIV_STEP: w = '{OP_DIV_STEP, C_DIV_MORE, STEP_DIV_STEP};
			STEP_DIV_END:  w = '{OP_DIV_END,  C_NEXT,     STEP_IDLE};
			STEP_EMIT:     w = '{OP_EMIT,     C_OUT_BUSY, STEP_EMIT};
			default:       w = '{OP_NOP,      C_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: src/rfa_div.sv
// One lane of restoring division, one quotient bit per step.
// Depends on rfa_pkg for the lane control struct.
module rfa_div import rfa_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  div_ctl_t         ctl,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient
);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   trial;
	logic             fits;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		shifted = {rem_q, quo_q[WIDTH-1]};
		trial   = shifted - {1'b0, divisor};
		fits    = !trial[WIDTH];
	end

	// The dividend shifts out of the quotient register as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (ctl.step) begin
			rem_q <= fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

FILE: src/rational_fraction_alu_core.sv
// Rational fraction ALU: add, subtract, multiply or divide two fractions and reduce.
// Depends on rfa_pkg, rfa_div and rational_fraction_alu_core_macros.svh.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_stall     action, a_num, a_den, b_num, b_den
//   out      output     out_valid / out_stall   res_num, res_den, undefined
//
// A microcoded sequencer runs each request through one shared multiplier, a
// binary GCD loop and two division lanes. An add or subtract also takes the
// second cross product and the numerator sum, which a multiply or divide skips;
// the GCD loop repeats until the pair is equal or holds a zero, and the division
// loop runs over all 2*OPERAND_WIDTH quotient bits; a zero over zero result
// skips the division steps and the step that takes the quotients.
// Requests are taken only in the idle step.
// Reset clears the step counter and the output valid flag.
// A stalled result holds the sequencer in its final step until the result register frees.
`include "rational_fraction_alu_core_macros.svh"

module rational_fraction_alu_core import rfa_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [NUM_OUT_W-1:0] res_num,
	output logic signed [DEN_OUT_W-1:0] res_den,
	output logic                        undefined
);

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = 2 * OPERAND_WIDTH;
	localparam int KW = $clog2(MW);
	localparam int CW = $clog2(MW + 1);
	localparam int XW = MW + NUM_OUT_W;

	// Sequencer state.
	pc_t    pc_q;
	pc_t    pc_next;
	uword_t uw;
	logic   jump;
	logic   in_acc;
	logic   out_acc;
	logic   out_busy;
	logic   out_valid_q;

	// Captured request in sign and magnitude form.
	action_t        action_q;
	logic           an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [W-1:0]   an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic           an_neg, ad_neg, bn_neg, bd_neg;
	logic [W-1:0]   an_mag, ad_mag, bn_mag, bd_mag;

	// Multiplier and accumulated fraction.
	logic           mul_xn, mul_yn, mul_flip;
	logic [W-1:0]   mul_x, mul_y;
	logic [MW-1:0]  mul_p;
	logic           p_neg_q;
	logic [MW-1:0]  p_mag_q;
	logic           num_neg_q, den_neg_q;
	logic [MW-1:0]  num_mag_q, den_mag_q;
	logic [MW:0]    sub_np;
	logic           add_neg;
	logic [MW-1:0]  add_mag;

	// GCD and division.
	logic [MW-1:0]  gx_q, gy_q, g_q;
	logic [KW-1:0]  gk_q;
	logic           gdone;
	logic [CW-1:0]  dcnt_q;
	div_ctl_t       div_ctl;
	logic [MW-1:0]  quo_num, quo_den;

	// Output register and final sign fixing.
	logic signed [NUM_OUT_W-1:0] res_num_q;
	logic signed [DEN_OUT_W-1:0] res_den_q;
	logic                        undefined_q;
	logic                        fin_neg;
	logic [XW-1:0]               num_ext, num_tc, den_ext;

	// Handshakes.
	assign in_stall = (pc_q != STEP_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_busy = out_valid_q && out_stall;

	// Split the input operands into sign and magnitude.
	always_comb begin
		an_neg = a_num[W-1];
		ad_neg = a_den[W-1];
		bn_neg = b_num[W-1];
		bd_neg = b_den[W-1];
		an_mag = an_neg ? W'(-a_num) : W'(a_num);
		ad_mag = ad_neg ? W'(-a_den) : W'(a_den);
		bn_mag = bn_neg ? W'(-b_num) : W'(b_num);
		bd_mag = bd_neg ? W'(-b_den) : W'(b_den);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_x    = an_mag_q;
		mul_xn   = an_neg_q;
		mul_y    = bd_mag_q;
		mul_yn   = bd_neg_q;
		mul_flip = 1'b0;
		case (uw.op)
			OP_MUL_A: begin
				if (action_q == ACT_MUL) begin
					mul_y  = bn_mag_q;
					mul_yn = bn_neg_q;
				end
			end
			OP_MUL_B: begin
				mul_x    = bn_mag_q;
				mul_xn   = bn_neg_q;
				mul_y    = ad_mag_q;
				mul_yn   = ad_neg_q;
				mul_flip = (action_q == ACT_SUB);
			end
			OP_MUL_D: begin
				mul_x  = ad_mag_q;
				mul_xn = ad_neg_q;
				if (action_q == ACT_DIV) begin
					mul_y  = bn_mag_q;
					mul_yn = bn_neg_q;
				end
			end
			default: begin
			end
		endcase
		mul_p = MW'(mul_x) * MW'(mul_y);
	end

	// Signed-magnitude sum of the numerator and the product register.
	always_comb begin
		sub_np = {1'b0, num_mag_q} - {1'b0, p_mag_q};
		if (num_neg_q == p_neg_q) begin
			add_neg = num_neg_q;
			add_mag = num_mag_q + p_mag_q;
		end else if (!sub_np[MW]) begin
			add_neg = num_neg_q;
			add_mag = sub_np[MW-1:0];
		end else begin
			add_neg = p_neg_q;
			add_mag = p_mag_q - num_mag_q;
		end
		if (add_mag == '0) begin
			add_neg = 1'b0;
		end
	end

	// Binary GCD finishes when the pair is equal or one of them is zero.
	assign gdone = (gx_q == '0) || (gy_q == '0) || (gx_q == gy_q);

	// Result sign and two's complement forms.
	always_comb begin
		fin_neg = (num_neg_q ^ (den_neg_q && (den_mag_q != '0))) && (num_mag_q != '0);
		num_ext = XW'(num_mag_q);
		num_tc  = fin_neg ? (~num_ext + XW'(1)) : num_ext;
		den_ext = XW'(den_mag_q);
	end

	// Jump condition and next step.
	always_comb begin
		uw = ucode_rom(pc_q);
		unique case (uw.cond)
			C_NEXT:     jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_REQ:   jump = !in_acc;
			C_MULDIV:   jump = (action_q == ACT_MUL) || (action_q == ACT_DIV);
			C_GCD_BUSY: jump = !gdone;
			C_G_ZERO:   jump = (g_q == '0);
			C_DIV_MORE: jump = (dcnt_q != CW'(1));
			C_OUT_BUSY: jump = out_busy;
			default:    jump = 1'b0;
		endcase
		if (jump) begin
			pc_next = uw.target;
		end else if (pc_q == STEP_LAST) begin
			pc_next = STEP_IDLE;
		end else begin
			pc_next = pc_q + pc_t'(1);
		end
	end

	// Step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (uw.op == OP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Division lane control.
	always_comb begin
		div_ctl.load = (uw.op == OP_DIV_LOAD);
		div_ctl.step = (uw.op == OP_DIV_STEP);
	end

	rfa_div #(
		.WIDTH(MW)
	) u_div_num (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (num_mag_q),
		.divisor  (g_q),
		.quotient (quo_num)
	);

	rfa_div #(
		.WIDTH(MW)
	) u_div_den (
		.clk      (clk),
		.ctl      (div_ctl),
		.dividend (den_mag_q),
		.divisor  (g_q),
		.quotient (quo_den)
	);

	// Datapath registers, written as the control word directs.
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_LOAD: begin
				if (in_acc) begin
					action_q <= action_t'(action);
					an_neg_q <= an_neg;
					ad_neg_q <= ad_neg;
					bn_neg_q <= bn_neg;
					bd_neg_q <= bd_neg;
					an_mag_q <= an_mag;
					ad_mag_q <= ad_mag;
					bn_mag_q <= bn_mag;
					bd_mag_q <= bd_mag;
				end
			end
			OP_MUL_A, OP_MUL_B, OP_MUL_D: begin
				p_mag_q <= mul_p;
				p_neg_q <= (mul_p != '0) && (mul_xn ^ mul_yn ^ mul_flip);
			end
			OP_LD_NUM: begin
				num_mag_q <= p_mag_q;
				num_neg_q <= p_neg_q;
			end
			OP_ADD_NUM: begin
				num_mag_q <= add_mag;
				num_neg_q <= add_neg;
			end
			OP_LD_DEN: begin
				den_mag_q <= p_mag_q;
				den_neg_q <= p_neg_q;
			end
			OP_GCD_INIT: begin
				gx_q <= num_mag_q;
				gy_q <= den_mag_q;
				gk_q <= '0;
			end
			OP_GCD_STEP: begin
				if (!gdone) begin
					if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1;
						gy_q <= gy_q >> 1;
						gk_q <= gk_q + KW'(1);
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (gx_q > gy_q) begin
						gx_q <= gx_q - gy_q;
					end else begin
						gy_q <= gy_q - gx_q;
					end
				end
			end
			OP_GCD_FIN: begin
				g_q <= ((gx_q == '0) ? gy_q : gx_q) << gk_q;
			end
			OP_DIV_LOAD: begin
				dcnt_q <= CW'(MW);
			end
			OP_DIV_STEP: begin
				dcnt_q <= dcnt_q - CW'(1);
			end
			OP_DIV_END: begin
				num_mag_q <= quo_num;
				den_mag_q <= quo_den;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					res_num_q   <= num_tc[NUM_OUT_W-1:0];
					res_den_q   <= den_ext[DEN_OUT_W-1:0];
					undefined_q <= (den_mag_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign undefined = undefined_q;

	// A request always starts with the first multiplication.
	`RFA_ASSERT_NEXT(a_start_mul, clk, arst_n, in_acc, pc_q == STEP_MUL_A)
	// A GCD step never turns a nonzero pair into a pair holding zero.
	`RFA_ASSERT_NEXT(a_gcd_nonzero, clk, arst_n,
		(pc_q == STEP_GCD_STEP) && (gx_q != '0) && (gy_q != '0), (gx_q != '0) && (gy_q != '0))
	// The division loop never runs with an exhausted count.
	`RFA_ASSERT_IMP(a_div_count, clk, arst_n, pc_q == STEP_DIV_STEP, dcnt_q != '0)
	// A stalled result keeps the sequencer in its final step.
	`RFA_ASSERT_NEXT(a_emit_hold, clk, arst_n,
		(pc_q == STEP_EMIT) && out_valid_q && out_stall, pc_q == STEP_EMIT)

endmodule

FILE: tb/rational_fraction_alu_core_checker.sv
// Checker for the rational fraction ALU: watches both channels and predicts each result.
// Depends on rfa_pkg; instantiated by rational_fraction_alu_core_tb beside the block.
module rational_fraction_alu_core_checker import rfa_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [1:0]                      action,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic signed [NUM_OUT_W-1:0]     res_num,
	input  logic signed [DEN_OUT_W-1:0]     res_den,
	input  logic                            undefined,
	output int                              fail_count,
	output int                              pending
);

	typedef struct packed {
		logic signed [NUM_OUT_W-1:0] num;
		logic signed [DEN_OUT_W-1:0] den;
		logic                        undef;
	} fraction_t;

	// Reduced fractions still owed by the block, oldest first.
	fraction_t reduced_q[$];

	// Cross products, Euclidean GCD reduction and sign fix of one request.
	// Plain 64-bit arithmetic is exact for operands of 16 bits.
	function automatic fraction_t reduced_fraction(action_t op,
			logic signed [OPERAND_WIDTH-1:0] an, logic signed [OPERAND_WIDTH-1:0] ad,
			logic signed [OPERAND_WIDTH-1:0] bn, logic signed [OPERAND_WIDTH-1:0] bd);
		longint num, den;
		longint x, y, r;
		fraction_t res;
		case (op)
			ACT_ADD: begin
				num = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
				den = longint'(ad) * longint'(bd);
			end
			ACT_SUB: begin
				num = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
				den = longint'(ad) * longint'(bd);
			end
			ACT_MUL: begin
				num = longint'(an) * longint'(bn);
				den = longint'(ad) * longint'(bd);
			end
			default: begin
				num = longint'(an) * longint'(bd);
				den = longint'(ad) * longint'(bn);
			end
		endcase
		// A zero over zero result has a GCD of zero and stays as it is.
		x = (num < 0) ? -num : num;
		y = (den < 0) ? -den : den;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		if (x != 0) begin
			num = num / x;
			den = den / x;
		end
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		res.num = num[NUM_OUT_W-1:0];
		res.den = den[DEN_OUT_W-1:0];
		res.undef = (den == 0);
		return res;
	endfunction

	// Compare each accepted result with the oldest prediction, then record new requests.
	always_ff @(posedge clk or negedge arst_n) begin
		fraction_t want;
		if (!arst_n) begin
			reduced_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reduced_q.size() == 0) begin
					$error("result %0d/%0d arrived with no request outstanding",
						res_num, res_den);
					fail_count <= fail_count + 1;
				end else begin
					want = reduced_q.pop_front();
					if (res_num !== want.num || res_den !== want.den
							|| undefined !== want.undef) begin
						if (res_num !== want.num)
							$error("res_num: expected %0d, got %0d", want.num, res_num);
						if (res_den !== want.den)
							$error("res_den: expected %0d, got %0d", want.den, res_den);
						if (undefined !== want.undef)
							$error("undefined: expected %0b, got %0b", want.undef, undefined);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				reduced_q.push_back(reduced_fraction(action_t'(action),
					a_num, a_den, b_num, b_den));
			pending <= reduced_q.size();
		end
	end

endmodule

FILE: tb/rational_fraction_alu_core_tb.sv
// Top of the rational fraction ALU testbench: clock, reset, requests and the verdict.
// Depends on rfa_pkg, rational_fraction_alu_core and rational_fraction_alu_core_checker.
module rational_fraction_alu_core_tb;
	import rfa_pkg::*;

	localparam int OPERAND_WIDTH = 16;
	localparam int RANDOM_REQUESTS = 1500;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_ADD;
	logic signed [OPERAND_WIDTH-1:0] a_num = '0;
	logic signed [OPERAND_WIDTH-1:0] a_den = '0;
	logic signed [OPERAND_WIDTH-1:0] b_num = '0;
	logic signed [OPERAND_WIDTH-1:0] b_den = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [NUM_OUT_W-1:0] res_num;
	logic signed [DEN_OUT_W-1:0] res_den;
	logic undefined;
	int fail_count;
	int pending;

	rational_fraction_alu_core #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .undefined(undefined)
	);

	rational_fraction_alu_core_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .undefined(undefined),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle stretch length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		else
			return $urandom_range(20, 80);
	endfunction

	// Operand mix: full range, small values for frequent reduction, zero and extremes.
	function automatic logic [OPERAND_WIDTH-1:0] pick_operand();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return OPERAND_WIDTH'($urandom);
		else if (r < 75)
			return OPERAND_WIDTH'($signed($urandom_range(0, 40)) - 20);
		else if (r < 85)
			return '0;
		else
			case ($urandom_range(0, 4))
				0: return {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
				1: return {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
				2: return OPERAND_WIDTH'(1);
				3: return '1;
				default: return {1'b1, {(OPERAND_WIDTH-2){1'b0}}, 1'b1};
			endcase
	endfunction

	// Offer one request after an optional gap and hold it until the block takes it.
	task automatic send_request(action_t op, logic [OPERAND_WIDTH-1:0] an,
			logic [OPERAND_WIDTH-1:0] ad, logic [OPERAND_WIDTH-1:0] bn,
			logic [OPERAND_WIDTH-1:0] bd, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Reset once, then the directed requests, the random requests and the verdict.
	initial begin
		bit burst;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain sums and products, then zero numerators and zero denominators.
		send_request(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 0);
		send_request(ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1);
		send_request(ACT_MUL, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 0);
		send_request(ACT_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5, 2);
		send_request(ACT_DIV, -16'sd3, 16'sd4, 16'sd0, 16'sd5, 0);
		send_request(ACT_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd7, 0);
		send_request(ACT_DIV, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 3);
		send_request(ACT_ADD, 16'sd0, 16'sd3, 16'sd0, -16'sd7, 0);
		send_request(ACT_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 0);
		send_request(ACT_ADD, 16'sd3, 16'sd0, 16'sd2, 16'sd5, 1);
		send_request(ACT_DIV, 16'sd0, -16'sd9, -16'sd4, 16'sd7, 0);
		send_request(ACT_MUL, 16'sd0, 16'sd5, 16'sd0, 16'sd0, 0);
		// Extreme magnitudes and negative denominators.
		send_request(ACT_ADD, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1, 0);
		send_request(ACT_MUL, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1, 2);
		send_request(ACT_ADD, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0);
		send_request(ACT_SUB, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 0);
		send_request(ACT_SUB, 16'sd32767, 16'sd1, -16'sd32768, 16'sd1, 0);
		send_request(ACT_DIV, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1);
		send_request(ACT_ADD, 16'sd5, -16'sd32768, 16'sd7, -16'sd32768, 0);
		send_request(ACT_MUL, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 0);
		send_request(ACT_SUB, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 0);
		send_request(ACT_SUB, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 4);
		send_request(ACT_DIV, 16'sd12345, -16'sd2, -16'sd6789, 16'sd3, 0);

		// Random requests, with some stretches sent back to back.
		burst = 1'b0;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 100 == 0)
				burst = ($urandom_range(0, 3) == 0);
			send_request(action_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand(), burst ? 0 : idle_len());
		end
		in_valid <= 1'b0;
		// Let the checker count the last request before looking at its backlog.
		@(posedge clk);

		// Wait for every result, then a little longer for anything stray.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("rational_fraction_alu_core_tb: clean");
		else
			$display("rational_fraction_alu_core_tb: errors");
		$finish;
	end

	// Result side: random stalls, calm stretches, and one long hold-off that fills the block.
	initial begin
		int elapsed;
		int stretch;
		bit held_long;
		elapsed = 0;
		held_long = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held_long && elapsed > 3000) begin
				held_long = 1'b1;
				out_stall <= 1'b1;
				repeat (2000) @(posedge clk);
				elapsed += 2000;
			end
			stretch = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 20);
			out_stall <= 1'b0;
			repeat (stretch) @(posedge clk);
			elapsed += stretch;
			stretch = idle_len();
			if (stretch > 0) begin
				out_stall <= 1'b1;
				repeat (stretch) @(posedge clk);
				elapsed += stretch;
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("rational_fraction_alu_core_tb: errors");
		$finish;
	end

endmodule
